@@ src/scfl_pkg.sv @@
package scfl_pkg;

    localparam int ADDR_W       = 16;
    localparam int SIZE_W       = 8;
    localparam int REGION_TRIES = 8;

    typedef enum logic [1:0] {
        OP_ALLOC   = 2'd0,
        OP_FREE    = 2'd1,
        OP_REALLOC = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_SIZE = 2'd1,
        ST_NO_MEM   = 2'd2
    } t_status;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_DIV    = 10'b0000000010,
        S_PUSH   = 10'b0000000100,
        S_AHEAD  = 10'b0000001000,
        S_POP_RD = 10'b0000010000,
        S_POP_WB = 10'b0000100000,
        S_CHECK  = 10'b0001000000,
        S_CARVE  = 10'b0010000000,
        S_SEARCH = 10'b0100000000,
        S_DONE   = 10'b1000000000
    } t_state;

    typedef struct packed {
        logic              bad;
        logic [SIZE_W-1:0] cls;
    } t_size_class;

endpackage

@@ src/scfl_div.sv @@
module scfl_div #(
    parameter int DW      = 16,
    parameter int DIVISOR = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    output logic          o_done,
    output logic [DW-1:0] o_quotient
);

    // The quotient is a multiply by the rounded-up reciprocal, which is exact
    // for every DW-bit dividend.
    localparam int SH = DW + $clog2(DIVISOR);
    localparam int MW = DW + 2;
    localparam int PW = DW + MW;
    localparam longint unsigned MUL = ((64'd1 << SH) + 64'(DIVISOR) - 64'd1)
                                      / 64'(DIVISOR);

    logic          r_done;
    logic [DW-1:0] r_q;
    logic [PW-1:0] prod;

    assign prod = PW'(i_dividend) * PW'(MUL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q <= DW'(prod >> SH);
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

@@ src/scfl_link_mem.sv @@
module scfl_link_mem #(
    parameter int DEPTH = 8192,
    parameter int AW    = 13,
    parameter int DW    = 14
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/size_class_free_list_allocator.sv @@
// Size-class free-list allocator over a fixed arena.
// Input channel: i_in_valid / o_in_stall carry one request beat with operation,
// block address, old size and new size. Output channel: o_out_valid / i_out_stall
// carry one result beat per request with the block address and a status code.
// A request is taken only while the sequencer is idle; o_in_stall is high otherwise.
// An allocate served from its list reads the head, then reads and writes back
// the link (AHEAD, POP_RD, POP_WB). A refill carves up to REFILL_COUNT blocks,
// each carved block costing one write of the link memory. Each replacement of the
// carve region scans the size classes one at a time, then pops a block.
// A free runs the address through the granule divider first, then pushes the block.
// A reallocate costs a free followed by an allocate.
// The result sits in an output register; when the receiver stalls, the beat holds
// and the next request may still be taken and worked on until its result is ready.
// Reset empties all class lists and sets the carve region to the whole arena.
// The link memory is not cleared; no entry is read before it is written.
module size_class_free_list_allocator
    import scfl_pkg::*;
#(
    parameter int ARENA_BYTES     = 65536,
    parameter int NUM_CLASSES     = 16,
    parameter int GRANULE_BYTES   = 8,
    parameter int MAX_BLOCK_BYTES = 128,
    parameter int REFILL_COUNT    = 20
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_operation,
    input  logic [ADDR_W-1:0] i_block_address,
    input  logic [SIZE_W-1:0] i_size_bytes,
    input  logic [SIZE_W-1:0] i_new_size_bytes,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [ADDR_W-1:0] o_result_address,
    output logic [1:0]        o_status
);

    localparam int LINK_COUNT = ARENA_BYTES / GRANULE_BYTES;
    localparam int GW         = $clog2(LINK_COUNT);
    localparam int HW         = $clog2(LINK_COUNT + 1);
    localparam int SW         = HW + 8;
    localparam int CW         = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int IW         = $clog2(REFILL_COUNT + 1);
    localparam int TW         = $clog2(REGION_TRIES + 1);
    localparam int CLS_SH     = SIZE_W + $clog2(GRANULE_BYTES);
    localparam int CLS_PW     = 2 * SIZE_W + 2;
    localparam longint unsigned CLS_MUL = ((64'd1 << CLS_SH) + 64'(GRANULE_BYTES) - 64'd1)
                                          / 64'(GRANULE_BYTES);

    function automatic t_size_class f_class(input logic [SIZE_W-1:0] size);
        t_size_class       res;
        logic [SIZE_W-1:0] d;
        logic [CLS_PW-1:0] prod;
        logic [SIZE_W-1:0] q;
        d    = size - SIZE_W'(1);
        prod = CLS_PW'(d) * CLS_PW'(CLS_MUL);
        q    = SIZE_W'(prod >> CLS_SH);
        res.cls = q;
        res.bad = (size == '0) || ({5'd0, size} > 13'(MAX_BLOCK_BYTES))
                  || (q >= SIZE_W'(NUM_CLASSES));
        return res;
    endfunction

    t_state          r_state, n_state;
    t_op             r_op, n_op;
    logic [CW-1:0]   r_cls, n_cls;
    logic [CW-1:0]   r_cls_new, n_cls_new;
    logic [TW-1:0]   r_tries, n_tries;
    logic [CW-1:0]   r_k, n_k;
    logic [GW-1:0]   r_pop_g, n_pop_g;
    logic            r_region, n_region;
    logic [GW-1:0]   r_first, n_first;
    logic [HW-1:0]   r_first1, n_first1;
    logic [HW-1:0]   r_pos, n_pos;
    logic [GW-1:0]   r_prev, n_prev;
    logic            r_prev_v, n_prev_v;
    logic [IW-1:0]   r_idx, n_idx;
    logic [HW-1:0]   r_carve_next, n_carve_next;
    logic [HW-1:0]   r_carve_limit, n_carve_limit;
    logic [ADDR_W-1:0] r_res, n_res;
    t_status         r_stat, n_stat;
    logic            r_out_valid;
    logic [ADDR_W-1:0] r_out_addr;
    t_status         r_out_stat;
    logic [HW-1:0]   r_heads [NUM_CLASSES];

    logic            accept;
    logic            out_free;
    t_size_class     cls_old;
    t_size_class     cls_new;
    logic [CW-1:0]   hd_ridx;
    logic [HW-1:0]   head_rd;
    logic            hd_we;
    logic [CW-1:0]   hd_widx;
    logic [HW-1:0]   hd_wdata;
    logic            lk_we;
    logic [GW-1:0]   lk_waddr;
    logic [HW-1:0]   lk_wdata;
    logic [HW-1:0]   lk_rdata;
    logic            div_start;
    logic            div_done;
    logic [ADDR_W-1:0] div_q;
    logic            q_ok;
    logic [HW-1:0]   left;
    logic [CW-1:0]   c_left;
    logic [SW-1:0]   bytes_g;
    logic [SW-1:0]   end_check;
    logic [SW-1:0]   end_carve;
    logic [SW-1:0]   lim_sum;
    logic            have;
    logic [TW-1:0]   tries_inc;

    scfl_div #(
        .DW      (ADDR_W),
        .DIVISOR (GRANULE_BYTES)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_block_address),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    scfl_link_mem #(
        .DEPTH (LINK_COUNT),
        .AW    (GW),
        .DW    (HW)
    ) u_links (
        .i_clk   (i_clk),
        .i_we    (lk_we),
        .i_waddr (lk_waddr),
        .i_wdata (lk_wdata),
        .i_raddr (r_pop_g),
        .o_rdata (lk_rdata)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign cls_old    = f_class(i_size_bytes);
    assign cls_new    = f_class(i_new_size_bytes);

    assign q_ok      = 32'(div_q) < 32'(LINK_COUNT);
    assign left      = (r_carve_limit > r_carve_next) ? r_carve_limit - r_carve_next : '0;
    assign c_left    = CW'(left - HW'(1));
    assign bytes_g   = SW'(r_cls) + SW'(1);
    assign end_check = SW'(r_carve_next) + bytes_g;
    assign end_carve = SW'(r_pos) + bytes_g;
    assign lim_sum   = SW'(r_pop_g) + SW'(r_k) + SW'(1);
    assign have      = (r_idx < IW'(REFILL_COUNT)) && (end_carve <= SW'(r_carve_limit));
    assign tries_inc = r_tries + TW'(1);

    always_comb begin
        case (r_state)
            S_CHECK:  hd_ridx = c_left;
            S_SEARCH: hd_ridx = r_k;
            default:  hd_ridx = r_cls;
        endcase
    end

    assign head_rd = r_heads[hd_ridx];

    always_comb begin
        n_state       = r_state;
        n_op          = r_op;
        n_cls         = r_cls;
        n_cls_new     = r_cls_new;
        n_tries       = r_tries;
        n_k           = r_k;
        n_pop_g       = r_pop_g;
        n_region      = r_region;
        n_first       = r_first;
        n_first1      = r_first1;
        n_pos         = r_pos;
        n_prev        = r_prev;
        n_prev_v      = r_prev_v;
        n_idx         = r_idx;
        n_carve_next  = r_carve_next;
        n_carve_limit = r_carve_limit;
        n_res         = r_res;
        n_stat        = r_stat;
        hd_we         = 1'b0;
        hd_widx       = r_cls;
        hd_wdata      = '0;
        lk_we         = 1'b0;
        lk_waddr      = r_prev;
        lk_wdata      = head_rd;
        div_start     = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_op      = t_op'(i_operation);
                    n_cls     = CW'(cls_old.cls);
                    n_cls_new = CW'(cls_new.cls);
                    n_tries   = '0;
                    n_res     = '0;
                    n_stat    = ST_OK;
                    case (t_op'(i_operation))
                        OP_ALLOC: begin
                            if (cls_old.bad) begin
                                n_stat  = ST_BAD_SIZE;
                                n_state = S_DONE;
                            end else begin
                                n_state = S_AHEAD;
                            end
                        end
                        OP_FREE: begin
                            if (cls_old.bad) begin
                                n_stat  = ST_BAD_SIZE;
                                n_state = S_DONE;
                            end else begin
                                div_start = 1'b1;
                                n_state   = S_DIV;
                            end
                        end
                        OP_REALLOC: begin
                            if (cls_old.bad || cls_new.bad) begin
                                n_stat  = ST_BAD_SIZE;
                                n_state = S_DONE;
                            end else begin
                                div_start = 1'b1;
                                n_state   = S_DIV;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (q_ok) begin
                    lk_we    = 1'b1;
                    lk_waddr = GW'(div_q);
                    lk_wdata = head_rd;
                    hd_we    = 1'b1;
                    hd_widx  = r_cls;
                    hd_wdata = HW'(div_q) + HW'(1);
                end
                if (r_op == OP_FREE) begin
                    n_state = S_DONE;
                end else begin
                    n_cls   = r_cls_new;
                    n_state = S_AHEAD;
                end
            end
            S_AHEAD: begin
                if (head_rd != '0) begin
                    n_pop_g  = GW'(head_rd - HW'(1));
                    n_region = 1'b0;
                    n_state  = S_POP_RD;
                end else begin
                    n_state = S_CHECK;
                end
            end
            S_POP_RD: begin
                n_state = S_POP_WB;
            end
            S_POP_WB: begin
                hd_we    = 1'b1;
                hd_widx  = r_region ? r_k : r_cls;
                hd_wdata = lk_rdata;
                if (!r_region) begin
                    n_res   = ADDR_W'(32'(r_pop_g) * 32'(GRANULE_BYTES));
                    n_stat  = ST_OK;
                    n_state = S_DONE;
                end else if (tries_inc == TW'(REGION_TRIES)) begin
                    n_carve_next  = '0;
                    n_carve_limit = '0;
                    n_res         = '0;
                    n_stat        = ST_NO_MEM;
                    n_state       = S_DONE;
                end else begin
                    n_tries       = tries_inc;
                    n_carve_next  = HW'(r_pop_g);
                    n_carve_limit = (lim_sum > SW'(LINK_COUNT)) ? HW'(LINK_COUNT)
                                                                : HW'(lim_sum);
                    n_state       = S_CHECK;
                end
            end
            S_CHECK: begin
                if (end_check <= SW'(r_carve_limit)) begin
                    n_first  = GW'(r_carve_next);
                    n_first1 = HW'(end_check);
                    n_pos    = HW'(end_check);
                    n_idx    = IW'(1);
                    n_prev_v = 1'b0;
                    n_state  = S_CARVE;
                end else begin
                    if (left != '0) begin
                        lk_we    = 1'b1;
                        lk_waddr = GW'(r_carve_next);
                        lk_wdata = head_rd;
                        hd_we    = 1'b1;
                        hd_widx  = c_left;
                        hd_wdata = r_carve_next + HW'(1);
                    end
                    n_carve_next  = '0;
                    n_carve_limit = '0;
                    n_k           = r_cls;
                    n_state       = S_SEARCH;
                end
            end
            S_CARVE: begin
                if (have) begin
                    if (r_prev_v) begin
                        lk_we    = 1'b1;
                        lk_waddr = r_prev;
                        lk_wdata = r_pos + HW'(1);
                    end
                    n_prev   = GW'(r_pos);
                    n_prev_v = 1'b1;
                    n_pos    = HW'(end_carve);
                    n_idx    = r_idx + IW'(1);
                end else begin
                    if (r_prev_v) begin
                        lk_we    = 1'b1;
                        lk_waddr = r_prev;
                        lk_wdata = head_rd;
                        hd_we    = 1'b1;
                        hd_widx  = r_cls;
                        hd_wdata = r_first1 + HW'(1);
                    end
                    n_carve_next = r_pos;
                    n_res        = ADDR_W'(32'(r_first) * 32'(GRANULE_BYTES));
                    n_stat       = ST_OK;
                    n_state      = S_DONE;
                end
            end
            S_SEARCH: begin
                if (head_rd != '0) begin
                    n_pop_g  = GW'(head_rd - HW'(1));
                    n_region = 1'b1;
                    n_state  = S_POP_RD;
                end else if (32'(r_k) == 32'(NUM_CLASSES - 1)) begin
                    n_res   = '0;
                    n_stat  = ST_NO_MEM;
                    n_state = S_DONE;
                end else begin
                    n_k = r_k + CW'(1);
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_carve_next  <= '0;
            r_carve_limit <= HW'(LINK_COUNT);
            r_out_valid   <= 1'b0;
            r_region      <= 1'b0;
            r_prev_v      <= 1'b0;
            r_tries       <= '0;
        end else begin
            r_state       <= n_state;
            r_carve_next  <= n_carve_next;
            r_carve_limit <= n_carve_limit;
            r_region      <= n_region;
            r_prev_v      <= n_prev_v;
            r_tries       <= n_tries;
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_cls     <= n_cls;
        r_cls_new <= n_cls_new;
        r_k       <= n_k;
        r_pop_g   <= n_pop_g;
        r_first   <= n_first;
        r_first1  <= n_first1;
        r_pos     <= n_pos;
        r_prev    <= n_prev;
        r_idx     <= n_idx;
        r_res     <= n_res;
        r_stat    <= n_stat;
        if (r_state == S_DONE && out_free) begin
            r_out_addr <= r_res;
            r_out_stat <= r_stat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CLASSES; i++) begin
                r_heads[i] <= '0;
            end
        end else if (hd_we) begin
            r_heads[hd_widx] <= hd_wdata;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_result_address = r_out_addr;
    assign o_status         = r_out_stat;

endmodule

@@ tb/sv/tb_size_class_free_list_allocator.sv @@
module tb_size_class_free_list_allocator;
    import scfl_pkg::*;

    localparam int ARENA      = 65536;
    localparam int CLASSES    = 16;
    localparam int GRANULE    = 8;
    localparam int MAX_BLOCK  = 128;
    localparam int REFILL     = 20;
    localparam int LINKS      = ARENA / GRANULE;
    localparam int QUIET_MAX  = 4000;
    localparam int TAIL_WAIT  = 300;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [ADDR_W-1:0] addr;
        t_status           st;
    } grant_t;

    typedef struct {
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] size;
    } live_block_t;

    logic              i_clk            = 1'b0;
    logic              i_rst_n          = 1'b0;
    logic              i_in_valid       = 1'b0;
    logic              o_in_stall;
    logic [1:0]        i_operation      = '0;
    logic [ADDR_W-1:0] i_block_address  = '0;
    logic [SIZE_W-1:0] i_size_bytes     = '0;
    logic [SIZE_W-1:0] i_new_size_bytes = '0;
    logic              o_out_valid;
    logic              i_out_stall      = 1'b0;
    logic [ADDR_W-1:0] o_result_address;
    logic [1:0]        o_status;

    logic [13:0] free_head [CLASSES];
    logic [13:0] free_link [LINKS];
    logic [16:0] carve_ptr;
    logic [16:0] carve_end;

    grant_t      pending_grants [$];
    live_block_t live_blocks [$];
    grant_t      last_grant;
    int          failures    = 0;
    int          quiet_cycles = 0;
    bit          steady_flow = 1'b0;

    size_class_free_list_allocator DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_operation      (i_operation),
        .i_block_address  (i_block_address),
        .i_size_bytes     (i_size_bytes),
        .i_new_size_bytes (i_new_size_bytes),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_result_address (o_result_address),
        .o_status         (o_status)
    );

    always #10 i_clk = ~i_clk;

    function automatic int unsigned class_for_size(int unsigned size);
        int unsigned c;
        if (size == 0 || size > MAX_BLOCK) return CLASSES;
        c = (size + GRANULE - 1) / GRANULE - 1;
        return (c < CLASSES) ? c : CLASSES;
    endfunction

    function automatic void list_push(int unsigned cls, int unsigned addr);
        int unsigned g;
        g = addr / GRANULE;
        if (g >= LINKS || cls >= CLASSES) return;
        free_link[g]   = free_head[cls];
        free_head[cls] = 14'(g + 1);
    endfunction

    function automatic int unsigned list_pop(int unsigned cls);
        int unsigned g;
        g = free_head[cls] - 1;
        if (g >= LINKS) begin
            free_head[cls] = '0;
            return 0;
        end
        free_head[cls] = free_link[g];
        return g * GRANULE;
    endfunction

    function automatic t_status carve_or_pop(int unsigned size, output int unsigned addr);
        int unsigned c, bytes, left, n, first, a, lim;
        bit found;
        addr = 0;
        c = class_for_size(size);
        if (c >= CLASSES) return ST_BAD_SIZE;
        if (free_head[c] != 0) begin
            addr = list_pop(c);
            return ST_OK;
        end
        bytes = (c + 1) * GRANULE;
        for (int t = 0; t < REGION_TRIES; t++) begin
            left = (carve_end > carve_ptr) ? carve_end - carve_ptr : 0;
            found = 1'b0;
            if (left >= bytes) begin
                n = left / bytes;
                if (n > REFILL) n = REFILL;
                first = carve_ptr;
                carve_ptr = 17'(first + n * bytes);
                for (int i = n - 1; i >= 1; i--) list_push(c, first + i * bytes);
                addr = first;
                return ST_OK;
            end
            if (left >= GRANULE) list_push(left / GRANULE - 1, carve_ptr);
            carve_ptr = '0;
            carve_end = '0;
            for (int k = c; k < CLASSES; k++) begin
                if (free_head[k] != 0) begin
                    a = list_pop(k);
                    lim = a + (k + 1) * GRANULE;
                    carve_ptr = 17'(a);
                    carve_end = 17'((lim > ARENA) ? ARENA : lim);
                    found = 1'b1;
                    break;
                end
            end
            if (!found) return ST_NO_MEM;
        end
        carve_ptr = '0;
        carve_end = '0;
        return ST_NO_MEM;
    endfunction

    function automatic void serve_request(logic [1:0] op, logic [ADDR_W-1:0] addr,
                                          logic [SIZE_W-1:0] size, logic [SIZE_W-1:0] nsize,
                                          output grant_t g);
        int unsigned got;
        got = 0;
        g.st = ST_OK;
        case (op)
            OP_ALLOC: begin
                g.st = carve_or_pop(size, got);
            end
            OP_FREE: begin
                if (class_for_size(size) >= CLASSES) g.st = ST_BAD_SIZE;
                else list_push(class_for_size(size), addr);
            end
            OP_REALLOC: begin
                if (class_for_size(size) >= CLASSES || class_for_size(nsize) >= CLASSES) begin
                    g.st = ST_BAD_SIZE;
                end else begin
                    list_push(class_for_size(size), addr);
                    g.st = carve_or_pop(nsize, got);
                end
            end
            default: ;
        endcase
        g.addr = got[ADDR_W-1:0];
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_flow || r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [SIZE_W-1:0] legal_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return 8'd1;
        if (r < 16) return 8'(MAX_BLOCK);
        return 8'($urandom_range(1, MAX_BLOCK));
    endfunction

    function automatic live_block_t take_live_block();
        int idx;
        live_block_t blk;
        idx = $urandom_range(0, live_blocks.size() - 1);
        blk = live_blocks[idx];
        live_blocks.delete(idx);
        return blk;
    endfunction

    task automatic issue_request(logic [1:0] op, logic [ADDR_W-1:0] addr,
                                 logic [SIZE_W-1:0] size, logic [SIZE_W-1:0] nsize);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_operation      <= op;
        i_block_address  <= addr;
        i_size_bytes     <= size;
        i_new_size_bytes <= nsize;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        serve_request(op, addr, size, nsize, last_grant);
        pending_grants.push_back(last_grant);
        if ((op == OP_ALLOC || op == OP_REALLOC) && last_grant.st == ST_OK)
            live_blocks.push_back('{last_grant.addr, (op == OP_ALLOC) ? size : nsize});
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_grants.size() != 0);
    endtask

    task automatic test_size_errors();
        issue_request(OP_ALLOC, 16'h0000, 8'd0, 8'd8);
        issue_request(OP_ALLOC, 16'h1234, 8'd129, 8'd0);
        issue_request(OP_ALLOC, 16'hFFFF, 8'd255, 8'd255);
        issue_request(OP_FREE, 16'h0040, 8'd0, 8'd16);
        issue_request(OP_FREE, 16'h0080, 8'd200, 8'd16);
        issue_request(OP_REALLOC, 16'h0100, 8'd0, 8'd8);
        issue_request(OP_REALLOC, 16'h0100, 8'd8, 8'd129);
    endtask

    task automatic test_unknown_operation();
        issue_request(OP_UNUSED, 16'($urandom), 8'($urandom), 8'($urandom));
        issue_request(OP_UNUSED, 16'hFFFF, 8'hFF, 8'hFF);
    endtask

    task automatic test_refill_and_pop();
        issue_request(OP_ALLOC, 16'h0000, 8'd1, 8'd0);
        issue_request(OP_ALLOC, 16'h0000, 8'd8, 8'd0);
        issue_request(OP_ALLOC, 16'h0000, 8'd128, 8'd0);
        issue_request(OP_ALLOC, 16'h0000, 8'd121, 8'd0);
    endtask

    task automatic test_free_reuse();
        live_block_t blk;
        issue_request(OP_ALLOC, 16'h0000, 8'd16, 8'd0);
        blk = live_blocks.pop_back();
        // The low address bits below the granule must be ignored by the free.
        issue_request(OP_FREE, blk.addr | 16'd3, 8'd16, 8'd0);
        issue_request(OP_ALLOC, 16'h0000, 8'd9, 8'd0);
        blk = live_blocks.pop_back();
        issue_request(OP_REALLOC, blk.addr, 8'd16, 8'd100);
        issue_request(OP_FREE, 16'hFFFF, 8'd1, 8'd0);
        issue_request(OP_ALLOC, 16'h0000, 8'd1, 8'd0);
        issue_request(OP_FREE, 16'h0000, 8'd128, 8'd0);
        issue_request(OP_ALLOC, 16'h0000, 8'd128, 8'd1);
        drain_results();
    endtask

    task automatic test_exhaust_arena();
        int tries;
        for (int cls = CLASSES - 1; cls >= 0; cls--) begin
            tries = 0;
            do begin
                issue_request(OP_ALLOC, 16'($urandom),
                              8'($urandom_range(cls * GRANULE + 1, cls * GRANULE + GRANULE)),
                              8'($urandom));
                tries++;
            end while (last_grant.st != ST_NO_MEM && tries < 2000);
        end
        drain_results();
    endtask

    task automatic test_clipped_region();
        // A block at the top of the arena freed twice links to itself, so the
        // region search keeps finding a block that clips to a single granule.
        issue_request(OP_FREE, 16'hFFF8, 8'd128, 8'd0);
        issue_request(OP_FREE, 16'hFFF8, 8'd128, 8'd0);
        issue_request(OP_ALLOC, 16'h0000, 8'd120, 8'd0);
        issue_request(OP_ALLOC, 16'h0000, 8'd8, 8'd0);
        issue_request(OP_ALLOC, 16'h0000, 8'd128, 8'd0);
        drain_results();
    endtask

    task automatic random_segment(int count, int alloc_pct, int free_pct, int realloc_pct);
        int r;
        live_block_t blk;
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r >= alloc_pct && r < alloc_pct + free_pct && live_blocks.size() != 0) begin
                blk = take_live_block();
                if ($urandom_range(0, 3) == 0) blk.addr = blk.addr | 16'($urandom_range(0, 7));
                issue_request(OP_FREE, blk.addr, blk.size, 8'($urandom));
            end else if (r >= alloc_pct + free_pct && r < alloc_pct + free_pct + realloc_pct
                         && live_blocks.size() != 0) begin
                blk = take_live_block();
                issue_request(OP_REALLOC, blk.addr, blk.size, legal_size());
            end else if (r >= alloc_pct + free_pct + realloc_pct) begin
                issue_request(2'($urandom), 16'($urandom), 8'($urandom), 8'($urandom));
            end else begin
                issue_request(OP_ALLOC, 16'($urandom), legal_size(), 8'($urandom));
            end
        end
        drain_results();
    endtask

    task automatic test_random_traffic();
        random_segment(350, 50, 30, 12);
        steady_flow = 1'b1;
        random_segment(200, 45, 35, 12);
        steady_flow = 1'b0;
        random_segment(500, 70, 15, 8);
        random_segment(350, 25, 55, 12);
    endtask

    always begin : out_backpressure
        int stall_len;
        repeat ($urandom_range(1, 6)) @(posedge i_clk);
        stall_len = pick_gap();
        if (stall_len > 0) begin
            i_out_stall <= 1'b1;
            repeat (stall_len) @(posedge i_clk);
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : result_check
        grant_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_grants.size() == 0) begin
                $error("unexpected result beat: result_address %h, status %0d",
                       o_result_address, o_status);
                failures++;
            end else begin
                want = pending_grants.pop_front();
                if (o_result_address !== want.addr) begin
                    $error("result_address: expected %h, actual %h", want.addr, o_result_address);
                    failures++;
                end
                if (o_status !== want.st) begin
                    $error("status: expected %0d, actual %0d", want.st, o_status);
                    failures++;
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_MAX) begin
            $display("tb_size_class_free_list_allocator failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        for (int c = 0; c < CLASSES; c++) free_head[c] = '0;
        for (int g = 0; g < LINKS; g++) free_link[g] = '0;
        carve_ptr = '0;
        carve_end = 17'(ARENA);
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_size_errors();
        test_unknown_operation();
        test_refill_and_pop();
        test_free_reuse();
        test_exhaust_arena();
        test_clipped_region();
        test_random_traffic();
        drain_results();
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (failures == 0 && pending_grants.size() == 0) begin
            $display("tb_size_class_free_list_allocator passed");
        end else begin
            $display("tb_size_class_free_list_allocator failed");
        end
        $finish;
    end

endmodule
